/* src/prsf_pkg.sv */
// Shared codes and constants of the pressure response scale and filter unit.
`timescale 1ns / 1ps
package prsf_pkg;

  typedef enum logic [1:0] {
    CMD_READ   = 2'd0,
    CMD_FILT   = 2'd1,
    CMD_CAL    = 2'd2,
    CMD_FRESET = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_TIMEOUT = 3'd1,
    STAT_SHORT   = 3'd2,
    STAT_ADDR    = 3'd3,
    STAT_FUNC    = 3'd4,
    STAT_COUNT   = 3'd5
  } stat_t;

  localparam logic [1:0] REG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] REG_DECIMALS   = 2'd1;
  localparam logic [1:0] REG_ALPHA      = 2'd2;

  localparam logic [7:0]  SLAVE_ADDR_RST = 8'd2;
  localparam logic [1:0]  DECIMALS_RST   = 2'd3;
  // 0.469 in unsigned Q0.16
  localparam logic [15:0] ALPHA_RST      = 16'd30736;

  localparam logic [7:0] FUNC_READ  = 8'h03;
  localparam logic [7:0] DATA_BYTES = 8'd2;
  localparam logic [4:0] MIN_RX     = 5'd5;
  localparam logic [4:0] MIN_FRAME  = 5'd7;

  localparam int DEN_W = 10;

  function automatic logic [DEN_W-1:0] pow10(input logic [1:0] d);
    logic [DEN_W-1:0] p;
    unique case (d)
      2'd0: p = 10'd1;
      2'd1: p = 10'd10;
      2'd2: p = 10'd100;
      default: p = 10'd1000;
    endcase
    return p;
  endfunction

endpackage

/* src/prsf_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module prsf_div #(
  parameter int NW = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [NW-1:0]               num,
  input  logic [prsf_pkg::DEN_W-1:0]  den,
  output logic                        done,
  output logic [NW-1:0]               quot
);
  import prsf_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  dsr;
  logic [DEN_W:0]    rem_sh;
  logic              qbit;
  logic [DEN_W:0]    rem_diff;

  assign rem_sh   = {rem, quot[NW-1]};
  assign qbit     = (rem_sh >= {1'b0, dsr});
  assign rem_diff = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out the top while quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem  <= '0;
      dsr  <= den;
    end else if (busy) begin
      quot <= {quot[NW-2:0], qbit};
      rem  <= qbit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

endmodule

/* src/pressure_response_scale_filter_unit.sv */
// Top level: response check, scaling sequencer, offset and low-pass filter.
`timescale 1ns / 1ps
// One request in, one result out. A failed read or a filter reset goes from idle
// straight to S_DONE; a good read passes through S_DIV and S_CORR, and a primed
// filtered read also through S_MUL and S_ADD, before S_DONE. S_DONE loads the result
// register once the output is free. The bit-serial divider scales the raw value by
// 1/10^decimals at one quotient bit per cycle. s_axis_tready is high only while the
// sequencer is idle, and the sequencer goes idle again on the cycle after the load. A
// request therefore holds the block until its result is loaded, which also waits while
// the previous result still holds the result register. The result register lets a new
// request in while the last result waits.
module pressure_response_scale_filter_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // transfer_ok[0], rx_len[5:1], resp_addr[13:6], resp_func[21:14],
  // resp_count[29:22], data_high[37:30], data_low[45:38], zero fill
  input  logic [47:0]                 s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]                  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // pressure_value[31:0], filtered_value[63:32], failed_reads[95:64],
  // good_reads[127:96]
  output logic [127:0]                m_axis_tdata,
  // status[2:0]
  output logic [2:0]                  m_axis_tuser,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [15:0]                 cfg_data
);
  import prsf_pkg::*;

  localparam int NW = 16 + FRAC_BITS;
  localparam int EW = (NW > 32) ? NW + 1 : 33;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_CORR = 6'b000100,
    S_MUL  = 6'b001000,
    S_ADD  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [7:0]  dev_addr;
  logic [1:0]  dec_digits;
  logic [15:0] filt_coef;

  logic signed [31:0] offset_value;
  logic signed [31:0] last_pressure;
  logic signed [31:0] filter_value;
  logic               filter_primed;
  logic [31:0]        fail_total;
  logic [31:0]        ok_total;

  cmd_t               cmd;
  stat_t              status;
  stat_t              in_status;
  logic               neg;
  logic signed [31:0] scaled;
  logic signed [49:0] prod;

  // input fields
  logic        transfer_ok;
  logic [4:0]  rx_len;
  logic [7:0]  resp_addr, resp_func, resp_count;
  logic [15:0] raw;
  logic [15:0] mag;

  assign transfer_ok = s_axis_tdata[0];
  assign rx_len      = s_axis_tdata[5:1];
  assign resp_addr   = s_axis_tdata[13:6];
  assign resp_func   = s_axis_tdata[21:14];
  assign resp_count  = s_axis_tdata[29:22];
  assign raw         = {s_axis_tdata[37:30], s_axis_tdata[45:38]};
  assign mag         = raw[15] ? 16'(~raw + 16'd1) : raw;

  always_comb begin
    priority if (!transfer_ok || rx_len < MIN_RX) in_status = STAT_TIMEOUT;
    else if (rx_len < MIN_FRAME)                 in_status = STAT_SHORT;
    else if (resp_addr != dev_addr)              in_status = STAT_ADDR;
    else if (resp_func != FUNC_READ)             in_status = STAT_FUNC;
    else if (resp_count != DATA_BYTES)           in_status = STAT_COUNT;
    else                                         in_status = STAT_OK;
  end

  logic                  in_acc;
  logic                  div_start;
  logic                  div_done;
  logic [NW-1:0]         div_num;
  logic [DEN_W-1:0]      div_den;
  logic [NW-1:0]         quot;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign div_den   = pow10(dec_digits);
  // rounding half of the divisor added up front: ties go away from zero
  assign div_num   = NW'({mag, {FRAC_BITS{1'b0}}}) + NW'(div_den >> 1);
  assign div_start = in_acc && (cmd_t'(s_axis_tuser) != CMD_FRESET) && (in_status == STAT_OK);

  prsf_div #(.NW(NW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  // signed saturation of the magnitude quotient
  logic [EW-1:0]      qx;
  logic signed [31:0] scaled_next;

  assign qx = EW'(quot);

  always_comb begin
    if (!neg) begin
      scaled_next = (qx > EW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(qx[31:0]);
    end else begin
      scaled_next = (qx > EW'(32'h8000_0000)) ? 32'sh8000_0000
                                               : $signed(32'(~qx[31:0] + 32'd1));
    end
  end

  // offset correction
  logic signed [32:0] corr;
  logic signed [31:0] x_sat;

  assign corr  = 33'(scaled) - 33'(offset_value);
  assign x_sat = (corr > 33'sd2147483647)  ? 32'sh7FFF_FFFF :
                 (corr < -33'sd2147483648) ? 32'sh8000_0000 : corr[31:0];

  // filter step
  logic signed [32:0] fdiff;
  logic signed [49:0] rnd;
  logic signed [34:0] fsum;
  logic signed [31:0] f_sat;

  assign fdiff = 33'(last_pressure) - 33'(filter_value);
  assign rnd   = prod + 50'sd32768;
  assign fsum  = 35'(filter_value) + 35'($signed(rnd[49:16]));
  assign f_sat = (fsum > 35'sd2147483647)  ? 32'sh7FFF_FFFF :
                 (fsum < -35'sd2147483648) ? 32'sh8000_0000 : fsum[31:0];

  logic out_free;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) state_next = div_start ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (div_done) state_next = S_CORR;
      end
      S_CORR: begin
        state_next = (cmd == CMD_FILT && filter_primed) ? S_MUL : S_DONE;
      end
      S_MUL:  state_next = S_ADD;
      S_ADD:  state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      dev_addr       <= SLAVE_ADDR_RST;
      dec_digits     <= DECIMALS_RST;
      filt_coef      <= ALPHA_RST;
      offset_value   <= '0;
      last_pressure  <= '0;
      filter_value   <= '0;
      filter_primed  <= 1'b0;
      fail_total     <= '0;
      ok_total       <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_SLAVE_ADDR: dev_addr   <= cfg_data[7:0];
          REG_DECIMALS:   dec_digits <= cfg_data[1:0];
          REG_ALPHA:      filt_coef  <= cfg_data;
          default: ;
        endcase
      end

      if (in_acc) begin
        if (cmd_t'(s_axis_tuser) == CMD_FRESET) begin
          filter_value  <= '0;
          filter_primed <= 1'b0;
        end else if (in_status != STAT_OK) begin
          fail_total <= fail_total + 32'd1;
        end
      end

      if (state == S_CORR) begin
        last_pressure <= x_sat;
        ok_total      <= ok_total + 32'd1;
        if (cmd == CMD_CAL) begin
          offset_value <= scaled;
        end else if (cmd == CMD_FILT && !filter_primed) begin
          filter_value  <= x_sat;
          filter_primed <= 1'b1;
        end
      end

      if (state == S_ADD) filter_value <= f_sat;

      if (state == S_DONE && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready)          m_axis_tvalid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd    <= cmd_t'(s_axis_tuser);
      status <= (cmd_t'(s_axis_tuser) == CMD_FRESET) ? STAT_OK : in_status;
      neg    <= raw[15];
    end
    if (state == S_DIV && div_done) scaled <= scaled_next;
    if (state == S_MUL) prod <= 50'(fdiff) * 50'($signed({1'b0, filt_coef}));
    if (state == S_DONE && out_free) begin
      m_axis_tdata <= {ok_total, fail_total, filter_value, last_pressure};
      m_axis_tuser <= status;
    end
  end

endmodule

/* src/prsf_check.sv */
// Port-level assertions for the pressure response scale and filter unit.
`timescale 1ns / 1ps
module prsf_check (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic [2:0]   m_axis_tuser
);
  import prsf_pkg::*;

  // one request at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready stayed high after an accepted request");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser <= STAT_COUNT))
    else $error("result status code out of range");

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed or dropped");

endmodule

bind pressure_response_scale_filter_unit prsf_check u_prsf_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
